>>> design/process_state_table_macros.svh
// Assertion macros used by the process state table engine (pst_back).
`ifndef PROCESS_STATE_TABLE_MACROS_SVH
`define PROCESS_STATE_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge, skipped while reset is low.
`define PST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every rising edge, reset included.
`define PST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/pst_pkg.sv
// Types and constants shared by the process state table modules.
package pst_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_GET    = 3'd2;
    localparam logic [2:0] CMD_LIST   = 3'd3;
    localparam logic [2:0] CMD_UPDATE = 3'd4;

    localparam logic [3:0] WAITING_RESET = 4'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LIST   = 3'd3,
        OP_UPDATE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [15:0] id;
        logic [3:0]  sc;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        t_status     status;
        logic [15:0] id;
        logic [3:0]  state;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  sc;
    } t_slot;

endpackage

>>> design/pst_front.sv
// Front end: accepts input transactions, decodes the command, drops unused codes.
module pst_front (
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_cmd,
    input  logic [15:0]     i_id,
    input  logic [3:0]      i_sc,
    input  logic            i_full,
    output pst_pkg::t_push  o_push
);
    import pst_pkg::*;

    logic known;
    t_op  op;

    always_comb begin
        known = 1'b1;
        op    = OP_INSERT;
        unique case (i_cmd)
            CMD_INSERT: op = OP_INSERT;
            CMD_DELETE: op = OP_DELETE;
            CMD_GET:    op = OP_GET;
            CMD_LIST:   op = OP_LIST;
            CMD_UPDATE: op = OP_UPDATE;
            default:    known = 1'b0;
        endcase
    end

    assign o_ready = !i_full;

    // Unused codes are taken and dropped here; they never reach the table.
    assign o_push.valid   = i_valid && !i_full && known;
    assign o_push.item.op = op;
    assign o_push.item.id = i_id;
    assign o_push.item.sc = i_sc;

endmodule

>>> design/pst_queue.sv
// Command queue between the front end and the table engine.
module pst_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pst_pkg::t_push  i_push,
    input  logic            i_pop,
    output pst_pkg::t_push  o_head,
    output logic            o_full
);
    import pst_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_rd;
    logic [QAW-1:0] r_wr;
    logic [QAW:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= '0;
            r_wr   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            unique case ({i_push.valid, i_pop})
                2'b10:   r_fill <= r_fill + (QAW+1)'(1);
                2'b01:   r_fill <= r_fill - (QAW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    assign o_head.valid = (r_fill != '0);
    assign o_head.item  = r_mem[r_rd];
    assign o_full       = (r_fill == (QAW+1)'(QDEPTH));

endmodule

>>> design/pst_back.sv
// Table engine: entry memory, newest-first scan, compaction on delete, result register.
`include "process_state_table_macros.svh"

module pst_back #(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_waiting,
    input  pst_pkg::t_push    i_head,
    output logic              o_pop,
    output logic              o_res_valid,
    output pst_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import pst_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS     = 9'b000000010,
        S_NONE    = 9'b000000100,
        S_RD      = 9'b000001000,
        S_CHK     = 9'b000010000,
        S_LEND    = 9'b000100000,
        S_SHRD    = 9'b001000000,
        S_SHWR    = 9'b010000000,
        S_DELDONE = 9'b100000000
    } t_bstate;

    t_slot       r_mem [ENTRIES];
    t_slot       r_rdata;

    t_bstate     r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic        r_pend_v, n_pend_v;
    logic [15:0] r_pend_id, n_pend_id;
    t_op         r_cmd;
    logic [15:0] r_id;
    logic [3:0]  r_sc;
    logic        r_ovalid;
    t_result     r_out;

    logic        out_free;
    logic        emit;
    t_result     e_res;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    t_slot       mem_wdata;
    logic        rd_en;
    logic [IW-1:0] rd_addr;
    logic        last_idx;

    assign out_free = !r_ovalid || i_res_ready;
    assign last_idx = (r_idx == '0);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_pend_v  = r_pend_v;
        n_pend_id = r_pend_id;
        o_pop     = 1'b0;
        emit      = 1'b0;
        e_res     = '{status: ST_OK, id: r_id, state: 4'd0, last: 1'b1};
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_rdata;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop    = 1'b1;
                    n_pend_v = 1'b0;
                    if (i_head.item.op == OP_INSERT) begin
                        n_state = S_INS;
                    end else if (r_count == '0) begin
                        n_state = (i_head.item.op == OP_UPDATE) ? S_IDLE : S_NONE;
                    end else begin
                        n_idx   = IW'(r_count - CW'(1));
                        n_state = S_RD;
                    end
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_count == CW'(ENTRIES)) begin
                        e_res.status = ST_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IW-1:0];
                        mem_wdata = '{id: r_id, sc: r_sc};
                        n_count   = r_count + CW'(1);
                    end
                end
            end
            S_NONE: begin
                if (out_free) begin
                    emit         = 1'b1;
                    e_res.status = ST_NONE;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_cmd == OP_LIST) begin
                    // Hold one waiting entry back until the next one shows it is not the last.
                    if (r_rdata.sc == i_waiting && r_pend_v && !out_free) begin
                        n_state = S_CHK;
                    end else begin
                        if (r_rdata.sc == i_waiting) begin
                            if (r_pend_v) begin
                                emit       = 1'b1;
                                e_res.id   = r_pend_id;
                                e_res.last = 1'b0;
                            end
                            n_pend_v  = 1'b1;
                            n_pend_id = r_rdata.id;
                        end
                        if (last_idx) begin
                            n_state = S_LEND;
                        end else begin
                            n_idx   = r_idx - IW'(1);
                            n_state = S_RD;
                        end
                    end
                end else if (r_rdata.id == r_id) begin
                    unique case (r_cmd)
                        OP_GET: begin
                            if (out_free) begin
                                emit        = 1'b1;
                                e_res.state = r_rdata.sc;
                                n_state     = S_IDLE;
                            end
                        end
                        OP_UPDATE: begin
                            mem_we    = 1'b1;
                            mem_wdata = '{id: r_rdata.id, sc: r_sc};
                            n_state   = S_IDLE;
                        end
                        OP_DELETE: begin
                            n_state = (CW'(r_idx) + CW'(1) < r_count) ? S_SHRD : S_DELDONE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end else if (last_idx) begin
                    n_state = (r_cmd == OP_UPDATE) ? S_IDLE : S_NONE;
                end else begin
                    n_idx   = r_idx - IW'(1);
                    n_state = S_RD;
                end
            end
            S_LEND: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (r_pend_v) begin
                        e_res.id = r_pend_id;
                    end else begin
                        e_res.status = ST_NONE;
                    end
                end
            end
            S_SHRD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + IW'(1);
                n_state = S_SHWR;
            end
            S_SHWR: begin
                // Move the younger neighbor down one place.
                mem_we  = 1'b1;
                n_idx   = r_idx + IW'(1);
                n_state = (CW'(r_idx) + CW'(2) < r_count) ? S_SHRD : S_DELDONE;
            end
            S_DELDONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_res_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id <= n_pend_id;
        if (o_pop) begin
            r_cmd <= i_head.item.op;
            r_id  <= i_head.item.id;
            r_sc  <= i_head.item.sc;
        end
        if (emit) begin
            r_out <= e_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res       = r_out;

    `PST_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "entry count past depth")
    `PST_ASSERT(a_count_dec, i_clk, i_rst_n, (r_count < $past(r_count)) |-> $past(r_state == S_DELDONE), "count dropped outside delete")
    `PST_ASSERT(a_notlast_list, i_clk, i_rst_n, (r_ovalid && !r_out.last) |-> (r_out.status == ST_OK && r_cmd == OP_LIST), "non-final result outside list")

endmodule

>>> design/process_state_table.sv
// Top level of the process state table: stream ports, waiting-code register, front, queue, engine.
// Usage:
//   Input stream (i_s_axis_*): one command per transaction; tuser carries the command,
//   tdata the process id and state code. Unused command codes are taken and dropped.
//   Output stream (o_m_axis_*): one result per transaction; tuser carries the status,
//   tdata the id and state, tlast marks the final result of a command.
//   Config: i_cfg_we writes i_cfg_wdata into the waiting code; write only while idle.
// Timing:
//   A command passes through a 4-deep queue, then the engine, which handles one command
//   at a time. Delete, get, update and list scan the entry memory newest first, each
//   entry examined by a registered read, then a compare; delete then moves each younger
//   entry down by a registered read, then a write.
//   List gives one result per waiting entry, each as the scan reaches the next one.
// Reset: the table is emptied and the waiting code set to 2; entry memory is not cleared.
// Stall: while o_m_axis_tvalid waits on i_m_axis_tready the engine holds at its next result;
//   the queue keeps accepting until full, then o_s_axis_tready drops.
module process_state_table #(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] proc_id, [19:16] state_code, [23:20] zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] out_id, [19:16] out_state, [23:20] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);
    import pst_pkg::*;

    logic [3:0] r_waiting_code;
    t_push      push;
    t_push      head;
    logic       q_full;
    logic       pop;
    logic       res_valid;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting_code <= WAITING_RESET;
        end else if (i_cfg_we) begin
            r_waiting_code <= i_cfg_wdata;
        end
    end

    pst_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (i_s_axis_tuser),
        .i_id    (i_s_axis_tdata[15:0]),
        .i_sc    (i_s_axis_tdata[19:16]),
        .i_full  (q_full),
        .o_push  (push)
    );

    pst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    pst_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_waiting   (r_waiting_code),
        .i_head      (head),
        .o_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tvalid = res_valid;
    assign o_m_axis_tdata  = {4'd0, res.state, res.id};
    assign o_m_axis_tuser  = res.status;
    assign o_m_axis_tlast  = res.last;

endmodule

>>> bench/process_state_table_tb.sv
// Testbench for the process state table: directed table then random traffic, checked by a predictor.
`timescale 1ns / 100ps

module process_state_table_tb;
    import pst_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int ITEMS_PHASE = 100;
    localparam int N_PHASES    = 5;
    localparam int SETTLE      = 400;   // queue depth plus engine, each at worst-case scan
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PRESS_PHASE = 4;
    localparam int PAUSE_PHASE = 1;
    localparam int MAX_PRINTS  = 100;

    // command codes the block takes and drops
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] id;
        logic [3:0]  sc;
        bit          typed;
        t_result     want;
    } t_dir_row;

    localparam t_result NO_WANT = '{ST_OK, 16'h0000, 4'h0, 1'b0};
    localparam int N_DIR = 23;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // [15:0] proc_id, [19:16] state_code, [23:20] zero
    logic [2:0]  i_s_axis_tuser;   // [2:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // [15:0] out_id, [19:16] out_state, [23:20] zero
    logic [1:0]  o_m_axis_tuser;   // [1:0] status
    logic        o_m_axis_tlast;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_wdata;

    // predicted table contents, oldest at index 0
    logic [15:0] tbl_id [ENTRIES];
    logic [3:0]  tbl_state [ENTRIES];
    int          tbl_count;
    logic [3:0]  wait_code;
    t_result     replies_due[$];

    int err_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    t_result got_want;

    t_dir_row directed [N_DIR] = '{
        '{CMD_GET,    16'h0000, 4'h0, 1'b1, '{ST_NONE, 16'h0000, 4'h0, 1'b1}},
        '{CMD_LIST,   16'hFFFF, 4'h0, 1'b1, '{ST_NONE, 16'hFFFF, 4'h0, 1'b1}},
        '{CMD_DELETE, 16'hFFFF, 4'hF, 1'b1, '{ST_NONE, 16'hFFFF, 4'h0, 1'b1}},
        '{CMD_UPDATE, 16'h0005, 4'hF, 1'b0, NO_WANT},
        '{CMD_INSERT, 16'h0000, 4'h2, 1'b1, '{ST_OK,   16'h0000, 4'h0, 1'b1}},
        '{CMD_INSERT, 16'hFFFF, 4'hF, 1'b1, '{ST_OK,   16'hFFFF, 4'h0, 1'b1}},
        '{CMD_INSERT, 16'h1234, 4'h2, 1'b1, '{ST_OK,   16'h1234, 4'h0, 1'b1}},
        '{CMD_INSERT, 16'h1234, 4'h5, 1'b1, '{ST_OK,   16'h1234, 4'h0, 1'b1}},
        '{CMD_GET,    16'h1234, 4'h0, 1'b0, NO_WANT},
        '{CMD_UPDATE, 16'h1234, 4'h2, 1'b0, NO_WANT},
        '{CMD_LIST,   16'h0001, 4'h0, 1'b0, NO_WANT},
        '{CMD_GET,    16'hFFFF, 4'h0, 1'b1, '{ST_OK,   16'hFFFF, 4'hF, 1'b1}},
        '{CMD_DELETE, 16'h1234, 4'h0, 1'b0, NO_WANT},
        '{CMD_LIST,   16'h0002, 4'h0, 1'b0, NO_WANT},
        '{CMD_SPARE5, 16'hFFFF, 4'hF, 1'b0, NO_WANT},
        '{CMD_SPARE6, 16'h0000, 4'h0, 1'b0, NO_WANT},
        '{CMD_SPARE7, 16'hA5A5, 4'h2, 1'b0, NO_WANT},
        '{CMD_DELETE, 16'h0000, 4'h0, 1'b0, NO_WANT},
        '{CMD_GET,    16'h0000, 4'h0, 1'b0, NO_WANT},
        '{CMD_INSERT, 16'hAAAA, 4'hA, 1'b1, '{ST_OK,   16'hAAAA, 4'h0, 1'b1}},
        '{CMD_INSERT, 16'h5555, 4'h5, 1'b1, '{ST_OK,   16'h5555, 4'h0, 1'b1}},
        '{CMD_UPDATE, 16'h7777, 4'h3, 1'b0, NO_WANT},
        '{CMD_LIST,   16'h5555, 4'h0, 1'b0, NO_WANT}
    };

    process_state_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result reply(t_status status, logic [15:0] id, logic [3:0] state,
                                      logic last);
        t_result r;
        r.status = status;
        r.id     = id;
        r.state  = state;
        r.last   = last;
        return r;
    endfunction

    function automatic int newest_slot(logic [15:0] id);
        for (int i = tbl_count - 1; i >= 0; i--) begin
            if (tbl_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Apply one command to the predicted table and queue the replies it owes.
    function automatic int apply_table_cmd(logic [2:0] cmd, logic [15:0] id, logic [3:0] sc);
        int pos;
        int n;
        pos = newest_slot(id);
        n = 0;
        case (cmd)
            CMD_INSERT: begin
                if (tbl_count >= ENTRIES) begin
                    replies_due.push_back(reply(ST_FULL, id, 4'h0, 1'b1));
                end else begin
                    tbl_id[tbl_count]    = id;
                    tbl_state[tbl_count] = sc;
                    tbl_count++;
                    replies_due.push_back(reply(ST_OK, id, 4'h0, 1'b1));
                end
                n = 1;
            end
            CMD_DELETE: begin
                if (pos < 0) begin
                    replies_due.push_back(reply(ST_NONE, id, 4'h0, 1'b1));
                end else begin
                    for (int i = pos; i + 1 < tbl_count; i++) begin
                        tbl_id[i]    = tbl_id[i + 1];
                        tbl_state[i] = tbl_state[i + 1];
                    end
                    tbl_count--;
                    replies_due.push_back(reply(ST_OK, id, 4'h0, 1'b1));
                end
                n = 1;
            end
            CMD_GET: begin
                if (pos < 0) replies_due.push_back(reply(ST_NONE, id, 4'h0, 1'b1));
                else replies_due.push_back(reply(ST_OK, id, tbl_state[pos], 1'b1));
                n = 1;
            end
            CMD_LIST: begin
                for (int i = tbl_count - 1; i >= 0; i--) begin
                    if (tbl_state[i] == wait_code) begin
                        replies_due.push_back(reply(ST_OK, tbl_id[i], 4'h0, 1'b0));
                        n++;
                    end
                end
                if (n == 0) begin
                    replies_due.push_back(reply(ST_NONE, id, 4'h0, 1'b1));
                    n = 1;
                end else begin
                    replies_due[replies_due.size() - 1].last = 1'b1;
                end
            end
            CMD_UPDATE: begin
                if (pos >= 0) tbl_state[pos] = sc;
            end
            default: ;
        endcase
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Offer one command with random gaps ahead of it; predict once it is taken.
    task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] id, input logic [3:0] sc,
                            output int n_replies);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = cmd;
        i_s_axis_tdata  = {4'h0, sc, id};
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_replies = apply_table_cmd(cmd, id, sc);
    endtask

    // Drop the offer, hold until every owed reply is in, then let silent updates finish.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_waiting_code(input logic [3:0] code);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = code;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        wait_code   = code;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result id=%h status=%0d",
                                          o_m_axis_tdata[15:0], o_m_axis_tuser));
            end else begin
                got_want = replies_due.pop_front();
                if (o_m_axis_tuser !== got_want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_m_axis_tuser, got_want.status));
                if (o_m_axis_tdata[15:0] !== got_want.id)
                    report_mismatch($sformatf("out_id %h, want %h",
                                              o_m_axis_tdata[15:0], got_want.id));
                if (o_m_axis_tdata[19:16] !== got_want.state)
                    report_mismatch($sformatf("out_state %h, want %h",
                                              o_m_axis_tdata[19:16], got_want.state));
                if (o_m_axis_tlast !== got_want.last)
                    report_mismatch($sformatf("last %b, want %b",
                                              o_m_axis_tlast, got_want.last));
            end
        end
    end

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int holds_served;
        int hold_left;
        holds_served    = 0;
        hold_left       = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready = 1'b0;
            end else begin
                i_m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run after too long without any transaction
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int         n_replies;
        int         counted;
        int         full_hits;
        int         roll;
        bit         filling;
        logic [2:0] cmd;
        logic [15:0] id;
        logic [3:0] sc;
        logic [15:0] id_pool [6];
        logic [3:0] phase_code [N_PHASES];
        int         phase_send [N_PHASES];
        int         phase_recv [N_PHASES];

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_INSERT;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        tbl_count       = 0;
        wait_code       = WAITING_RESET;
        err_count       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_requests   = 0;
        filling         = 1'b1;
        full_hits       = 0;

        phase_code = '{4'd0, 4'd15, WAITING_RESET, 4'($urandom_range(15)), 4'd15};
        phase_send = '{0, 87, 0, 16, 0};
        phase_recv = '{0, 0, 87, 16, 0};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table; typed rows replace the predicted reply
        foreach (directed[r]) begin
            send_cmd(directed[r].cmd, directed[r].id, directed[r].sc, n_replies);
            if (directed[r].typed) begin
                void'(replies_due.pop_back());
                replies_due.push_back(directed[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            write_waiting_code(phase_code[ph]);
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            foreach (id_pool[k]) id_pool[k] = 16'($urandom_range(16'hFFFF));
            counted = 0;
            while (counted < ITEMS_PHASE) begin
                if (ph == PRESS_PHASE && counted == 20 && hold_requests == 0) hold_requests++;
                if (ph == PAUSE_PHASE && counted == ITEMS_PHASE / 2) wait_drained();

                // Fill toward full, then drain toward empty, with lookups in between
                roll = $urandom_range(99);
                if (filling)
                    cmd = roll < 70 ? CMD_INSERT : roll < 80 ? CMD_GET : roll < 85 ? CMD_LIST :
                          roll < 95 ? CMD_UPDATE : CMD_DELETE;
                else
                    cmd = roll < 50 ? CMD_DELETE : roll < 60 ? CMD_INSERT : roll < 75 ? CMD_GET :
                          roll < 85 ? CMD_LIST : CMD_UPDATE;
                if ($urandom_range(99) < 3) cmd = 3'($urandom_range(CMD_SPARE7, CMD_SPARE5));

                if (tbl_count > 0 && cmd != CMD_INSERT && $urandom_range(99) < 70)
                    id = tbl_id[$urandom_range(tbl_count - 1)];
                else if ($urandom_range(99) < 10)
                    id = 16'($urandom_range(16'hFFFF));
                else
                    id = id_pool[$urandom_range(5)];
                sc = $urandom_range(1) ? wait_code : 4'($urandom_range(15));

                if (cmd == CMD_INSERT && tbl_count == ENTRIES) full_hits++;
                send_cmd(cmd, id, sc, n_replies);
                if (cmd <= CMD_UPDATE) counted++;

                if (filling && full_hits >= 2) begin
                    filling   = 1'b0;
                    full_hits = 0;
                end else if (!filling && tbl_count == 0) begin
                    filling = 1'b1;
                end
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        wait_drained();

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/pst_pkg.sv
design/pst_front.sv
design/pst_queue.sv
design/pst_back.sv
design/process_state_table.sv
bench/process_state_table_tb.sv
